// ===== sv/wfua_pkg.sv =====
// Package for the worst-fit unit allocator: field widths, command and status
// codes, the sequencer state type and the structs shared between modules.
// No dependencies.
package wfua_pkg;

   localparam int NUM_UNITS_DEFAULT = 1024;

   localparam int PID_W    = 8;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 2;
   localparam int START_W  = 10;
   localparam int LENGTH_W = 11;

   localparam logic CMD_ALLOCATE = 1'b0;
   localparam logic CMD_RELEASE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAILED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              used;
      logic [PID_W-1:0]  owner;
   } unit_entry_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic free;
   } scan_ctrl_type;

endpackage

// ===== sv/wfua_mem.sv =====
// Unit map memory: one used flag and one owner id per unit, one write port
// and one registered read port.
// Depends on wfua_pkg.
module wfua_mem #(
   parameter int DEPTH = wfua_pkg::NUM_UNITS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [AW-1:0]            waddr,
   input  wfua_pkg::unit_entry_type wdata,
   input  logic                     re,
   input  logic [AW-1:0]            raddr,
   output wfua_pkg::unit_entry_type rd_data
);

   wfua_pkg::unit_entry_type mem [DEPTH];
   wfua_pkg::unit_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/wfua_scan.sv =====
// Free-run tracker: one incrementer and one comparator, stepped once per unit,
// that keeps the current free run and the longest one seen so far.
// Depends on wfua_pkg.
module wfua_scan #(
   parameter int DEPTH = wfua_pkg::NUM_UNITS_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                    clock,
   input  wfua_pkg::scan_ctrl_type ctrl,
   input  logic [AW-1:0]           idx,
   output logic [CW-1:0]           best_len,
   output logic [AW-1:0]           best_start
);

   logic [CW-1:0] run_len_ff, run_len_in;
   logic [AW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] best_len_ff, best_len_in;
   logic [AW-1:0] best_start_ff, best_start_in;
   logic [CW-1:0] run_inc;
   logic [AW-1:0] cur_start;

   assign run_inc   = run_len_ff + CW'(1);
   assign cur_start = (run_len_ff == '0) ? idx : run_start_ff;

   always_comb begin
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      if (ctrl.clear) begin
         run_len_in    = '0;
         run_start_in  = '0;
         best_len_in   = '0;
         best_start_in = '0;
      end else if (ctrl.step) begin
         if (ctrl.free) begin
            run_len_in   = run_inc;
            run_start_in = cur_start;
            if (run_inc > best_len_ff) begin
               best_len_in   = run_inc;
               best_start_in = cur_start;
            end
         end else begin
            run_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
   end

   assign best_len   = best_len_ff;
   assign best_start = best_start_ff;

endmodule

// ===== sv/worst_fit_unit_allocator.sv =====
// Top level of the worst-fit unit allocator: command handshake, sequencer,
// unit map memory and free-run tracker.
// Depends on wfua_pkg, wfua_mem and wfua_scan.
//
// After reset the block is busy while it clears the unit map, one unit per
// cycle. A command is taken when start is high and busy is low. Every command
// reads the whole map through one memory read port, one unit per cycle; a
// granted allocate then writes the owner into each of its units through the
// single write port. The result is shown for one cycle with rsp_valid high
// and cannot be held off; busy falls in the cycle after it.
module worst_fit_unit_allocator #(
   parameter int NUM_UNITS = wfua_pkg::NUM_UNITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [wfua_pkg::PID_W-1:0]          req_process_id,
   input  logic [wfua_pkg::SIZE_W-1:0]         req_size,
   output logic                                rsp_valid,
   output logic [wfua_pkg::STATUS_W-1:0]       rsp_status,
   output logic [wfua_pkg::START_W-1:0]        rsp_start_unit,
   output logic [wfua_pkg::LENGTH_W-1:0]       rsp_length
);

   localparam int AW   = $clog2(NUM_UNITS);
   localparam int CW   = $clog2(NUM_UNITS + 1);
   localparam int CMPW = (CW > wfua_pkg::SIZE_W) ? CW : wfua_pkg::SIZE_W;

   wfua_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, cnt_inc;
   logic cmd_ff, cmd_in;
   logic [wfua_pkg::PID_W-1:0] pid_ff, pid_in;
   logic [wfua_pkg::SIZE_W-1:0] size_ff, size_in;
   logic rd_vld_ff, rd_vld_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [wfua_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [wfua_pkg::START_W-1:0] start_unit_ff, start_unit_in;
   logic [wfua_pkg::LENGTH_W-1:0] length_ff, length_in;

   logic mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   wfua_pkg::unit_entry_type mem_wdata, rd_data;
   wfua_pkg::scan_ctrl_type scan_ctrl;
   logic [CW-1:0] best_len;
   logic [AW-1:0] best_start;
   logic [AW+wfua_pkg::START_W-1:0] start_wide;
   logic fits;

   wfua_mem #(.DEPTH(NUM_UNITS), .AW(AW)) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re      (mem_re),
      .raddr   (mem_raddr),
      .rd_data (rd_data)
   );

   wfua_scan #(.DEPTH(NUM_UNITS), .AW(AW), .CW(CW)) u_scan (
      .clock      (clock),
      .ctrl       (scan_ctrl),
      .idx        (rd_idx_ff),
      .best_len   (best_len),
      .best_start (best_start)
   );

   assign cnt_inc    = cnt_ff + CW'(1);
   assign start_wide = {{wfua_pkg::START_W{1'b0}}, best_start};
   assign fits       = CMPW'(best_len) >= CMPW'(size_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      size_in       = size_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      status_in     = status_ff;
      start_unit_in = start_unit_ff;
      length_in     = length_ff;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff[AW-1:0];
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = cnt_ff[AW-1:0];
      scan_ctrl     = '0;
      busy          = 1'b1;
      case (state_ff)
         wfua_pkg::S_CLEAR: begin
            if (cnt_ff == CW'(NUM_UNITS)) begin
               cnt_in   = '0;
               state_in = wfua_pkg::S_IDLE;
            end else begin
               mem_we = 1'b1;
               cnt_in = cnt_inc;
            end
         end
         wfua_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd_in          = req_command;
               pid_in          = req_process_id;
               size_in         = req_size;
               cnt_in          = '0;
               scan_ctrl.clear = 1'b1;
               state_in        = wfua_pkg::S_SCAN;
            end
         end
         wfua_pkg::S_SCAN: begin
            if (cnt_ff != CW'(NUM_UNITS)) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[AW-1:0];
               cnt_in    = cnt_inc;
            end
            if (rd_vld_ff) begin
               scan_ctrl.step = 1'b1;
               scan_ctrl.free = !rd_data.used;
               if (cmd_ff == wfua_pkg::CMD_RELEASE && rd_data.used &&
                   rd_data.owner == pid_ff) begin
                  mem_we          = 1'b1;
                  mem_waddr       = rd_idx_ff;
                  mem_wdata.used  = 1'b0;
                  mem_wdata.owner = rd_data.owner;
               end
            end
            if (cnt_ff == CW'(NUM_UNITS) && !rd_vld_ff) begin
               state_in = wfua_pkg::S_DECIDE;
            end
         end
         wfua_pkg::S_DECIDE: begin
            cnt_in = '0;
            if (cmd_ff == wfua_pkg::CMD_RELEASE) begin
               status_in     = wfua_pkg::STATUS_RELEASED;
               start_unit_in = '0;
               length_in     = '0;
               state_in      = wfua_pkg::S_RESP;
            end else if (fits) begin
               status_in     = wfua_pkg::STATUS_ALLOCATED;
               start_unit_in = start_wide[wfua_pkg::START_W-1:0];
               length_in     = size_ff;
               state_in      = (size_ff == '0) ? wfua_pkg::S_RESP : wfua_pkg::S_WRITE;
            end else begin
               status_in     = wfua_pkg::STATUS_FAILED;
               start_unit_in = '0;
               length_in     = '0;
               state_in      = wfua_pkg::S_RESP;
            end
         end
         wfua_pkg::S_WRITE: begin
            mem_we          = 1'b1;
            mem_waddr       = best_start + cnt_ff[AW-1:0];
            mem_wdata.used  = 1'b1;
            mem_wdata.owner = pid_ff;
            cnt_in          = cnt_inc;
            if (CMPW'(cnt_inc) == CMPW'(size_ff)) begin
               state_in = wfua_pkg::S_RESP;
            end
         end
         wfua_pkg::S_RESP: begin
            state_in = wfua_pkg::S_IDLE;
         end
         default: begin
            state_in = wfua_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wfua_pkg::S_CLEAR;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      size_ff       <= size_in;
      rd_idx_ff     <= rd_idx_in;
      status_ff     <= status_in;
      start_unit_ff <= start_unit_in;
      length_ff     <= length_in;
   end

   assign rsp_valid      = (state_ff == wfua_pkg::S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_start_unit = start_unit_ff;
   assign rsp_length     = length_ff;

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("block not busy after a command transfer");

   a_failed_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == wfua_pkg::STATUS_FAILED) |->
      (rsp_start_unit == '0 && rsp_length == '0))
      else $error("failed allocate reports a nonzero run");

   a_write_owned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wfua_pkg::S_WRITE) |-> (mem_we && mem_wdata.used &&
      mem_wdata.owner == pid_ff && cmd_ff == wfua_pkg::CMD_ALLOCATE))
      else $error("grant write does not mark the unit for the requester");
`endif

endmodule

// ===== bench/worst_fit_unit_allocator_tb.sv =====
// Self-checking testbench for the worst-fit unit allocator: a directed table and then random
// allocate and release commands, each checked against a fixed result or a unit map predictor.
// Depends on wfua_pkg and worst_fit_unit_allocator.
module worst_fit_unit_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PID_W    = wfua_pkg::PID_W;
   localparam int SIZE_W   = wfua_pkg::SIZE_W;
   localparam int STATUS_W = wfua_pkg::STATUS_W;
   localparam int START_W  = wfua_pkg::START_W;
   localparam int LENGTH_W = wfua_pkg::LENGTH_W;

   localparam logic CMD_ALLOCATE = wfua_pkg::CMD_ALLOCATE;
   localparam logic CMD_RELEASE  = wfua_pkg::CMD_RELEASE;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = wfua_pkg::STATUS_ALLOCATED;
   localparam logic [STATUS_W-1:0] STATUS_FAILED    = wfua_pkg::STATUS_FAILED;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = wfua_pkg::STATUS_RELEASED;

   localparam int NUM_UNITS       = wfua_pkg::NUM_UNITS_DEFAULT;
   localparam int N_PLAN          = 26;
   localparam int N_RANDOM        = 264;
   localparam int N_ITEMS         = N_PLAN + N_RANDOM;
   localparam int SIZE_MAX        = (1 << SIZE_W) - 1;
   localparam int MAX_ITEM_CYCLES = 2 * NUM_UNITS + 4;
   localparam int DRAIN_CYCLES    = MAX_ITEM_CYCLES + 16;
   localparam int CYCLE_LIMIT     = 4 * (12 + NUM_UNITS + N_ITEMS * (MAX_ITEM_CYCLES + 32));

   typedef struct packed {
      logic              command;
      logic [PID_W-1:0]  pid;
      logic [SIZE_W-1:0] size;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [START_W-1:0]  start_unit;
      logic [LENGTH_W-1:0] length;
   } grant_type;

   typedef struct packed {
      request_type req;
      logic        fixed;
      grant_type   grant;
   } plan_row_type;

   localparam grant_type PREDICTED = '0;
   localparam grant_type RELEASED  = '{STATUS_RELEASED, 10'd0, 11'd0};
   localparam grant_type REFUSED   = '{STATUS_FAILED, 10'd0, 11'd0};

   localparam plan_row_type DIRECTED_PLAN [N_PLAN] = '{
      '{'{CMD_ALLOCATE, 8'h00, 11'd0}, 1'b1, '{STATUS_ALLOCATED, 10'd0, 11'd0}},
      '{'{CMD_ALLOCATE, 8'hff, 11'd1024}, 1'b1, '{STATUS_ALLOCATED, 10'd0, 11'd1024}},
      '{'{CMD_ALLOCATE, 8'h01, 11'd1}, 1'b1, REFUSED},
      '{'{CMD_ALLOCATE, 8'h01, 11'd0}, 1'b1, '{STATUS_ALLOCATED, 10'd0, 11'd0}},
      '{'{CMD_RELEASE, 8'h07, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_RELEASE, 8'hff, 11'd2047}, 1'b1, RELEASED},
      '{'{CMD_ALLOCATE, 8'h03, 11'd2047}, 1'b1, REFUSED},
      '{'{CMD_ALLOCATE, 8'h10, 11'd100}, 1'b1, '{STATUS_ALLOCATED, 10'd0, 11'd100}},
      '{'{CMD_ALLOCATE, 8'h20, 11'd200}, 1'b0, PREDICTED},
      '{'{CMD_RELEASE, 8'h10, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_ALLOCATE, 8'h30, 11'd724}, 1'b0, PREDICTED},
      '{'{CMD_ALLOCATE, 8'h40, 11'd100}, 1'b0, PREDICTED},
      '{'{CMD_RELEASE, 8'h20, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_ALLOCATE, 8'h50, 11'd0}, 1'b0, PREDICTED},
      '{'{CMD_ALLOCATE, 8'h50, 11'd150}, 1'b0, PREDICTED},
      '{'{CMD_ALLOCATE, 8'haa, 11'd50}, 1'b0, PREDICTED},
      '{'{CMD_RELEASE, 8'h30, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_RELEASE, 8'h40, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_RELEASE, 8'h50, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_RELEASE, 8'haa, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_ALLOCATE, 8'h01, 11'd10}, 1'b1, '{STATUS_ALLOCATED, 10'd0, 11'd10}},
      '{'{CMD_ALLOCATE, 8'h02, 11'd10}, 1'b0, PREDICTED},
      '{'{CMD_ALLOCATE, 8'h01, 11'd10}, 1'b0, PREDICTED},
      '{'{CMD_ALLOCATE, 8'h55, 11'd994}, 1'b0, PREDICTED},
      '{'{CMD_RELEASE, 8'h01, 11'd0}, 1'b1, RELEASED},
      '{'{CMD_ALLOCATE, 8'h66, 11'd5}, 1'b0, PREDICTED}
   };

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                req_command    = CMD_ALLOCATE;
   logic [PID_W-1:0]    req_process_id = '0;
   logic [SIZE_W-1:0]   req_size       = '0;
   logic                busy;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_start_unit;
   logic [LENGTH_W-1:0] rsp_length;

   bit               unit_taken [NUM_UNITS];
   logic [PID_W-1:0] unit_pid   [NUM_UNITS];
   logic [PID_W-1:0] pid_pool   [8];
   grant_type        awaited_grants [$];

   int failures = 0;
   int checked  = 0;
   int granted  = 0;
   int refused  = 0;
   int releases = 0;
   int cycles   = 0;

   worst_fit_unit_allocator #(
      .NUM_UNITS(NUM_UNITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_process_id(req_process_id),
      .req_size(req_size),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_start_unit(rsp_start_unit),
      .rsp_length(rsp_length)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic grant_type predict_grant(input request_type r);
      int        run_len;
      int        run_first;
      int        best_len;
      int        best_first;
      grant_type g;
      g = RELEASED;
      if (r.command == CMD_RELEASE) begin
         for (int u = 0; u < NUM_UNITS; u++) begin
            if (unit_taken[u] && unit_pid[u] == r.pid) unit_taken[u] = 1'b0;
         end
         return g;
      end
      run_len = 0;
      run_first = 0;
      best_len = 0;
      best_first = 0;
      for (int u = 0; u < NUM_UNITS; u++) begin
         if (!unit_taken[u]) begin
            if (run_len == 0) run_first = u;
            run_len++;
            if (run_len > best_len) begin
               best_len = run_len;
               best_first = run_first;
            end
         end else begin
            run_len = 0;
         end
      end
      if (best_len >= int'(r.size)) begin
         for (int u = best_first; u < best_first + int'(r.size); u++) begin
            unit_taken[u] = 1'b1;
            unit_pid[u] = r.pid;
         end
         g = '{STATUS_ALLOCATED, START_W'(best_first), r.size};
      end else begin
         g = REFUSED;
      end
      return g;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          roll;
      int          pick;
      roll = $urandom_range(0, 99);
      r.command = CMD_ALLOCATE;
      r.pid = pid_pool[$urandom_range(0, 7)];
      r.size = SIZE_W'($urandom_range(0, SIZE_MAX));
      if (roll < 60) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) r.size = SIZE_W'($urandom_range(1, 48));
         else if (pick < 90) r.size = SIZE_W'($urandom_range(49, 300));
         else if (pick < 97) r.size = SIZE_W'($urandom_range(301, NUM_UNITS));
         else r.size = '0;
      end else if (roll < 88) begin
         r.command = CMD_RELEASE;
      end else if (roll < 94) begin
         r.pid = PID_W'($urandom_range(0, 255));
      end else begin
         r.command = CMD_RELEASE;
         r.pid = PID_W'($urandom_range(0, 255));
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid) begin
         if (awaited_grants.size() == 0) begin
            $display("%0t: unexpected result: status %0d start %0d length %0d",
                     $time, rsp_status, rsp_start_unit, rsp_length);
            failures++;
         end else begin
            want = awaited_grants.pop_front();
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("start_unit", 16'(want.start_unit), 16'(rsp_start_unit));
            check_field("length", 16'(want.length), 16'(rsp_length));
            checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_grants.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      request_type cur;
      grant_type   cur_grant;
      grant_type   want;
      bit          cur_fixed;
      bit          have_item;
      bit          taken;
      int          n_sent;
      int          idle_pct;
      cur = '0;
      cur_grant = '0;
      cur_fixed = 1'b0;
      have_item = 1'b0;
      n_sent = 0;
      for (int k = 0; k < 8; k++) pid_pool[k] = PID_W'($urandom_range(0, 255));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (n_sent < N_ITEMS) begin
         @(posedge clock);
         taken = start && !busy;
         if (taken) begin
            want = predict_grant(cur);
            if (cur_fixed) want = cur_grant;
            case (want.status)
               STATUS_ALLOCATED: granted++;
               STATUS_FAILED:    refused++;
               default:          releases++;
            endcase
            awaited_grants.push_back(want);
            n_sent++;
            have_item = 1'b0;
         end
         if (!have_item && n_sent < N_ITEMS) begin
            if (n_sent < N_PLAN) begin
               cur = DIRECTED_PLAN[n_sent].req;
               cur_fixed = DIRECTED_PLAN[n_sent].fixed;
               cur_grant = DIRECTED_PLAN[n_sent].grant;
            end else begin
               cur = random_request();
               cur_fixed = 1'b0;
            end
            have_item = 1'b1;
         end
         idle_pct = (n_sent < N_ITEMS / 3) ? 9 : (n_sent < 2 * N_ITEMS / 3) ? 62 : 0;
         if (have_item && ((start && !taken) || $urandom_range(0, 99) >= idle_pct)) begin
            start <= 1'b1;
            req_command <= cur.command;
            req_process_id <= cur.pid;
            req_size <= cur.size;
         end else begin
            start <= 1'b0;
         end
      end
      while (awaited_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d commands: %0d allocations granted, %0d refused, %0d releases.",
               n_sent, granted, refused, releases);
      $display("Checked %0d results, %0d field mismatches or stray results.",
               checked, failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/wfua_pkg.sv
sv/wfua_mem.sv
sv/wfua_scan.sv
sv/worst_fit_unit_allocator.sv
bench/worst_fit_unit_allocator_tb.sv
